// ===== rtl/core/cll_pkg.sv =====
// Shared types and codes for the cursor linked list engine.
package cll_pkg;

	// Operation codes carried in the func field
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_APPEND = 2'd2;

	// Result status codes
	localparam logic [1:0] RS_OK    = 2'd0;
	localparam logic [1:0] RS_RANGE = 2'd1;
	localparam logic [1:0] RS_FULL  = 2'd2;

	// Sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_POP,
		S_WALK,
		S_LINK,
		S_DEL1,
		S_DEL2,
		S_DEL3,
		S_DONE
	} cll_state_t;

endpackage

// ===== rtl/core/cursor_linked_list_engine_unit.sv =====
// Cursor linked list engine: link store, value store and the step sequencer.
//
// A singly linked list of values kept in one store of DEPTH nodes. Node 0
// heads the free list, node DEPTH-1 heads the data list, and index 0 ends
// both chains, so at most DEPTH-2 elements fit. Each accepted word is one
// operation (insert before position, delete at position, append at tail)
// and gives one result word with a status and the new length. After reset
// the block lays out the free chain in the link memory and holds req_ready
// low meanwhile. The link memory has one read port with registered data,
// and the sequencer follows one link per cycle through it, so an insert or
// delete walks as far as its position and an append walks the whole list;
// a range error or an unused code skips the walk. A new word is taken only
// while the sequencer is idle; a finished result may still wait in the
// output register at that time.
module cursor_linked_list_engine_unit #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  func,
	input  logic [9:0]  position,
	input  logic [31:0] value,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [9:0]  length
);
	import cll_pkg::*;

	localparam int LW = $clog2(DEPTH);
	localparam logic [LW-1:0] HEAD     = LW'(DEPTH - 1);
	localparam logic [LW-1:0] LAST_FRE = LW'(DEPTH - 2);

	// Storage
	logic [LW-1:0]         link_mem [DEPTH];
	logic [DATA_WIDTH-1:0] val_mem  [DEPTH];

	cll_state_t            state_q, state_d;
	logic [LW-1:0]         clr_q;
	logic [LW-1:0]         count_q;
	logic                  rsp_valid_q;
	logic [LW-1:0]         rd_q;
	logic [1:0]            op_q;
	logic [9:0]            steps_q;
	logic [LW-1:0]         cur_q;
	logic [LW-1:0]         j_q;
	logic [LW-1:0]         del_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [1:0]            st_q;
	logic [1:0]            status_q;
	logic [9:0]            length_q;

	logic [LW-1:0]         rd_addr;
	logic                  wr_en;
	logic [LW-1:0]         wr_addr;
	logic [LW-1:0]         wr_data;
	logic                  val_wr;
	logic                  pos_bad;
	logic                  walk_end;
	logic                  done_go;
	logic [63:0]           val_ext;
	logic [LW+9:0]         cnt_ext;

	// Range check: position must be 1..length
	assign pos_bad  = (position == 10'd0) ||
		({{LW{1'b0}}, position} > {10'd0, count_q});
	assign walk_end = (op_q == FN_APPEND) ? (rd_q == '0) : (steps_q == 10'd0);
	assign done_go  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign val_ext  = {{32{value[31]}}, value};
	assign cnt_ext  = {10'd0, count_q};

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign length    = length_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == HEAD) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					case (func)
						FN_INSERT: state_d = pos_bad ? S_DONE : S_ALLOC;
						FN_DELETE: state_d = pos_bad ? S_DONE : S_WALK;
						FN_APPEND: state_d = S_ALLOC;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_ALLOC: state_d = (rd_q == '0) ? S_DONE : S_POP;
			S_POP:   state_d = S_WALK;
			S_WALK: begin
				if (walk_end) state_d = (op_q == FN_DELETE) ? S_DEL1 : S_LINK;
			end
			S_LINK:  state_d = S_DONE;
			S_DEL1:  state_d = S_DEL2;
			S_DEL2:  state_d = S_DEL3;
			S_DEL3:  state_d = S_DONE;
			S_DONE: begin
				if (done_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port control per state
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		val_wr  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				// free chain 1..DEPTH-2, both heads end at 0
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = (clr_q < LAST_FRE) ? LW'(clr_q + LW'(1)) : '0;
			end
			S_IDLE: begin
				rd_addr = (func == FN_DELETE) ? HEAD : '0;
			end
			S_ALLOC: begin
				// rd_q is the free head; fetch its successor
				rd_addr = rd_q;
			end
			S_POP: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = rd_q;
				rd_addr = HEAD;
			end
			S_WALK: begin
				rd_addr = rd_q;
				if (walk_end && (op_q != FN_DELETE)) begin
					// new node takes the old successor (0 at the tail)
					wr_en   = 1'b1;
					wr_addr = j_q;
					wr_data = rd_q;
					val_wr  = 1'b1;
				end
			end
			S_LINK: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = j_q;
			end
			S_DEL1: begin
				// predecessor skips the removed node
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = rd_q;
				rd_addr = '0;
			end
			S_DEL2: begin
				wr_en   = 1'b1;
				wr_addr = del_q;
				wr_data = rd_q;
			end
			S_DEL3: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = del_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// Link and value memories
	always_ff @(posedge clk) begin
		if (wr_en) link_mem[wr_addr] <= wr_data;
		rd_q <= link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (val_wr) val_mem[j_q] <= val_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= LW'(clr_q + LW'(1));
			if (state_q == S_LINK) count_q <= LW'(count_q + LW'(1));
			else if (state_q == S_DEL3) count_q <= LW'(count_q - LW'(1));
			if (done_go) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// Working registers and result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_q    <= func;
					val_q   <= val_ext[DATA_WIDTH-1:0];
					steps_q <= position - 10'd1;
					cur_q   <= HEAD;
					st_q    <= (pos_bad && (func == FN_INSERT || func == FN_DELETE)) ?
						RS_RANGE : RS_OK;
				end
			end
			S_ALLOC: begin
				j_q <= rd_q;
				if (rd_q == '0) st_q <= RS_FULL;
			end
			S_WALK: begin
				if (!walk_end) begin
					cur_q   <= rd_q;
					steps_q <= steps_q - 10'd1;
				end else if (op_q == FN_DELETE) begin
					del_q <= rd_q;
				end
			end
			S_DONE: begin
				if (done_go) begin
					status_q <= st_q;
					length_q <= cnt_ext[9:0];
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

endmodule

// ===== tb/sv/cursor_linked_list_engine_unit_tb.sv =====
// Testbench for the cursor linked list engine: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module cursor_linked_list_engine_unit_tb;
	import cll_pkg::*;

	localparam int DEPTH          = 1024;
	localparam int HEAD           = DEPTH - 1;
	localparam int CAPACITY       = DEPTH - 2;
	localparam int RAND_WORDS     = 500;
	localparam int GROW_WORDS     = 40;
	// slowest step walks about 1024 links, plus the free-chain clear after reset
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 50;
	localparam logic [1:0] FN_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  fn;
		logic [9:0]  pos;
		logic [31:0] val;
	} op_word_t;

	typedef struct {
		logic [1:0] status;
		logic [9:0] length;
	} list_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  func      = '0;
	logic [9:0]  position  = '0;
	logic [31:0] value     = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [1:0]  status;
	logic [9:0]  length;

	cursor_linked_list_engine_unit #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.length(length)
	);

	// predictor copy of the node store
	logic [9:0]  link_mem [DEPTH];
	logic [31:0] node_vals [DEPTH];
	int          list_len = 0;

	op_word_t     op_pending [$];
	list_result_t rsp_expected [$];

	int words_queued  = 0;
	int results_seen  = 0;
	int plan_len      = 0;
	int err_count     = 0;
	int stall_cycles  = 0;
	bit no_idle       = 1'b0;
	bit req_fired     = 1'b0;
	int send_gap      = 0;
	int send_calm     = 0;
	int hold_left     = 0;
	int recv_calm     = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t MISMATCH %s", $realtime, msg);
		err_count++;
	endtask

	// node whose link precedes 1-based position pos
	function automatic int link_before(input logic [9:0] pos);
		int cur;
		int s;
		cur = HEAD;
		for (s = 1; s < pos; s++)
			cur = link_mem[cur];
		return cur;
	endfunction

	function automatic list_result_t predict_result(input op_word_t w);
		list_result_t r;
		int cur;
		int node;
		r.status = RS_OK;
		case (w.fn)
			FN_INSERT: begin
				if (w.pos == 0 || w.pos > list_len) begin
					r.status = RS_RANGE;
				end else if (link_mem[0] == 0) begin
					r.status = RS_FULL;
				end else begin
					node = link_mem[0];
					link_mem[0] = link_mem[node];
					cur = link_before(w.pos);
					node_vals[node] = w.val;
					link_mem[node] = link_mem[cur];
					link_mem[cur] = node;
					list_len++;
				end
			end
			FN_DELETE: begin
				if (w.pos == 0 || w.pos > list_len) begin
					r.status = RS_RANGE;
				end else begin
					cur = link_before(w.pos);
					node = link_mem[cur];
					link_mem[cur] = link_mem[node];
					link_mem[node] = link_mem[0];
					link_mem[0] = node;
					list_len--;
				end
			end
			FN_APPEND: begin
				if (link_mem[0] == 0) begin
					r.status = RS_FULL;
				end else begin
					node = link_mem[0];
					link_mem[0] = link_mem[node];
					cur = HEAD;
					while (link_mem[cur] != 0)
						cur = link_mem[cur];
					node_vals[node] = w.val;
					link_mem[node] = '0;
					link_mem[cur] = node;
					list_len++;
				end
			end
			default: ;
		endcase
		r.length = 10'(list_len);
		return r;
	endfunction

	// queue one word and track the length it will leave behind
	function automatic void enqueue_word(input logic [1:0] fn, input logic [9:0] pos,
			input logic [31:0] val);
		op_word_t w;
		w.fn  = fn;
		w.pos = pos;
		w.val = val;
		op_pending.push_back(w);
		words_queued++;
		case (fn)
			FN_INSERT: if (pos != 0 && pos <= plan_len && plan_len < CAPACITY) plan_len++;
			FN_DELETE: if (pos != 0 && pos <= plan_len) plan_len--;
			FN_APPEND: if (plan_len < CAPACITY) plan_len++;
			default: ;
		endcase
	endfunction

	task automatic wait_drained();
		while (results_seen != words_queued)
			@(posedge clk);
	endtask

	// request driver: holds a word until taken, random gap bursts between words
	always @(negedge clk) begin
		op_word_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_fired) begin
			// word still waiting for acceptance
		end else if (send_gap > 0) begin
			req_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (op_pending.size() == 0) begin
			req_valid <= 1'b0;
		end else if (!no_idle && send_calm == 0 && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			send_gap <= $urandom_range(0, 3);
		end else begin
			nxt = op_pending.pop_front();
			req_valid <= 1'b1;
			func <= nxt.fn;
			position <= nxt.pos;
			value <= nxt.val;
			if (send_calm > 0)
				send_calm <= send_calm - 1;
			else if ($urandom_range(0, 15) == 0)
				send_calm <= $urandom_range(8, 40);
		end
	end

	// response side: random stall bursts, with calm stretches
	always @(negedge clk) begin
		if (!arst_n || no_idle) begin
			rsp_ready <= 1'b1;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (recv_calm > 0) begin
			rsp_ready <= 1'b1;
			recv_calm <= recv_calm - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			hold_left <= $urandom_range(0, 3);
		end else begin
			rsp_ready <= 1'b1;
			if ($urandom_range(0, 19) == 0)
				recv_calm <= $urandom_range(20, 80);
		end
	end

	// monitor: predict on each taken request word, check each taken result word
	always @(posedge clk) begin
		list_result_t want;
		req_fired <= arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_expected.size() == 0) begin
					flag_mismatch($sformatf("unexpected result status %0d length %0d",
						status, length));
				end else begin
					want = rsp_expected.pop_front();
					results_seen++;
					if (status !== want.status)
						flag_mismatch($sformatf("status got %0d want %0d (result %0d)",
							status, want.status, results_seen));
					if (length !== want.length)
						flag_mismatch($sformatf("length got %0d want %0d (result %0d)",
							length, want.length, results_seen));
				end
			end
			if (req_valid && req_ready)
				rsp_expected.push_back(predict_result('{func, position, value}));

			// watchdog on handshake progress
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		int top;
		int k;

		// predictor reset: free chain 1..DEPTH-2, empty data list
		for (k = 0; k < DEPTH; k++) begin
			link_mem[k] = '0;
			node_vals[k] = '0;
		end
		for (k = 0; k + 2 < DEPTH; k++)
			link_mem[k] = 10'(k + 1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, range edges, value extremes, spare code
		enqueue_word(FN_INSERT, 10'd1, 32'h0000_0001);
		enqueue_word(FN_DELETE, 10'd1, '0);
		enqueue_word(FN_DELETE, 10'd0, '0);
		enqueue_word(FN_SPARE, 10'd0, '0);
		enqueue_word(FN_APPEND, 10'd1023, 32'h7FFF_FFFF);
		enqueue_word(FN_APPEND, 10'd0, 32'h8000_0000);
		enqueue_word(FN_INSERT, 10'd1, 32'h0000_0000);
		enqueue_word(FN_INSERT, 10'd3, 32'hFFFF_FFFF);
		enqueue_word(FN_INSERT, 10'd5, 32'h1234_5678);
		enqueue_word(FN_INSERT, 10'd0, 32'h1234_5678);
		enqueue_word(FN_INSERT, 10'd1023, 32'hFFFF_FFFF);
		enqueue_word(FN_DELETE, 10'd4, '0);
		enqueue_word(FN_DELETE, 10'd5, '0);
		enqueue_word(FN_DELETE, 10'd1, '0);
		enqueue_word(FN_DELETE, 10'd1023, 32'hFFFF_FFFF);
		enqueue_word(FN_SPARE, 10'd1023, 32'hFFFF_FFFF);
		enqueue_word(FN_APPEND, 10'd512, 32'h5555_AAAA);
		enqueue_word(FN_DELETE, 10'd3, '0);
		enqueue_word(FN_DELETE, 10'd2, '0);
		enqueue_word(FN_DELETE, 10'd1, '0);
		enqueue_word(FN_DELETE, 10'd1, '0);
		enqueue_word(FN_APPEND, 10'd0, 32'hAAAA_5555);

		// sender holds off until every result is back
		wait_drained();

		// random: mostly well-formed positions, some wild ones and spare codes
		repeat (RAND_WORDS) begin
			pick = $urandom_range(0, 99);
			top = plan_len + 1;
			if (pick < 5) begin
				enqueue_word(FN_SPARE, 10'($urandom), $urandom);
			end else if (pick < 15) begin
				enqueue_word(pick < 10 ? FN_INSERT : FN_DELETE, 10'($urandom), $urandom);
			end else if (pick < 40 && plan_len < 64) begin
				enqueue_word(FN_APPEND, 10'($urandom), $urandom);
			end else if (pick < 70 && plan_len < 64) begin
				enqueue_word(FN_INSERT, 10'($urandom_range(0, top)), $urandom);
			end else begin
				enqueue_word(FN_DELETE, 10'($urandom_range(0, top)), $urandom);
			end
		end

		// let the random words go out before idling stops
		while (op_pending.size() != 0)
			@(posedge clk);

		// final stretch, no idling: grow the list, then probe the range edges
		no_idle = 1'b1;
		repeat (GROW_WORDS) begin
			if (plan_len == 0)
				enqueue_word(FN_APPEND, 10'($urandom), $urandom);
			else
				enqueue_word(FN_INSERT, 10'($urandom_range(1, plan_len < 4 ? plan_len : 4)),
					$urandom);
		end
		enqueue_word(FN_APPEND, 10'd0, 32'h0BAD_F00D);
		enqueue_word(FN_INSERT, 10'd1, 32'h0BAD_F00D);
		enqueue_word(FN_INSERT, 10'(CAPACITY), 32'h0BAD_F00D);
		enqueue_word(FN_INSERT, 10'd1023, 32'h0BAD_F00D);
		enqueue_word(FN_DELETE, 10'd0, '0);
		enqueue_word(FN_DELETE, 10'd1023, '0);
		enqueue_word(FN_DELETE, 10'(CAPACITY), '0);
		enqueue_word(FN_APPEND, 10'd7, 32'h8000_0001);
		enqueue_word(FN_DELETE, 10'd1, '0);
		enqueue_word(FN_INSERT, 10'(CAPACITY - 1), 32'h7FFF_FFFE);
		enqueue_word(FN_APPEND, 10'd0, 32'hFFFF_FFFF);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
